/* sv/julian_day_gregorian_convert_macros.svh */
// Assertion macros shared by the converter RTL.
`ifndef JULIAN_DAY_GREGORIAN_CONVERT_MACROS_SVH
`define JULIAN_DAY_GREGORIAN_CONVERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define JDG_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("jdgc: invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define JDG_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("jdgc: implication violated");

// Consequent holds in the cycle after the antecedent.
`define JDG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("jdgc: next-cycle implication violated");

`endif

/* sv/jdgc_pkg.sv */
// Constants, stage record and month table for the Julian day converter.
package jdgc_pkg;

  localparam int unsigned NSTG = 13;

  // Supported input ranges
  localparam logic [22:0] JD_MIN   = 23'd2299161;
  localparam logic [22:0] JD_MAX   = 23'd5373484;
  localparam logic [13:0] YEAR_MIN = 14'd1582;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  // floor((4z - 7468865) / 146097) by reciprocal, shift 24
  localparam logic [24:0] N1_BIAS = 25'd7468865;
  localparam logic [17:0] D1      = 18'd146097;
  localparam logic [6:0]  K1      = 7'd114;

  // floor((20b - 2442) / 7305) by reciprocal, shift 27
  localparam logic [11:0] N3_BIAS = 12'd2442;
  localparam logic [12:0] D3      = 13'd7305;
  localparam logic [14:0] K3      = 15'd18373;

  // floor(year / 100) by reciprocal, shift 14
  localparam logic [6:0]  DA      = 7'd100;
  localparam logic [7:0]  KA      = 8'd163;

  localparam logic [10:0] C1461   = 11'd1461;
  localparam logic [22:0] DD_BIAS = 23'd6890076;  // 1461 * 4716
  localparam logic [10:0] B_BIAS  = 11'd1525;     // 1 + 1524
  localparam logic [10:0] JD_BIAS = 11'd1522;     // 1524 - 2
  localparam logic [12:0] YR_OFS0 = 13'd4715;
  localparam logic [12:0] YR_OFS1 = 13'd4716;

  typedef struct packed {
    logic        action;
    logic        err;
    logic [22:0] z;
    logic [23:0] n1;
    logic [30:0] p1;
    logic [6:0]  q1e;
    logic [24:0] back1;
    logic [6:0]  w;
    logic [22:0] b;
    logic [26:0] n3;
    logic [41:0] p3;
    logic [14:0] q3e;
    logic [27:0] back3;
    logic [14:0] c;
    logic [23:0] d;
    logic [8:0]  g;
    logic [4:0]  e;
    logic [4:0]  day;
    logic [3:0]  mo_p;
    logic [13:0] yr_p;
    logic [21:0] pa;
    logic [7:0]  qa;
    logic [14:0] backa;
    logic [7:0]  a;
    logic [24:0] dd;
    logic [22:0] jd;
    logic [22:0] res_jd;
    logic [4:0]  res_d;
    logic [3:0]  res_m;
    logic [13:0] res_y;
  } item_t;

  // floor(30.6001 * k)
  function automatic logic [8:0] month_days(input logic [4:0] k);
    logic [8:0] r;
    unique case (k)
      5'd0:    r = 9'd0;
      5'd1:    r = 9'd30;
      5'd2:    r = 9'd61;
      5'd3:    r = 9'd91;
      5'd4:    r = 9'd122;
      5'd5:    r = 9'd153;
      5'd6:    r = 9'd183;
      5'd7:    r = 9'd214;
      5'd8:    r = 9'd244;
      5'd9:    r = 9'd275;
      5'd10:   r = 9'd306;
      5'd11:   r = 9'd336;
      5'd12:   r = 9'd367;
      5'd13:   r = 9'd397;
      5'd14:   r = 9'd428;
      5'd15:   r = 9'd459;
      5'd16:   r = 9'd489;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* sv/julian_day_gregorian_convert.sv */
// Top level: pipelined Julian day number <-> Gregorian date converter.
//
// Usage
//   Input channel (in_valid_i / in_ready_o) takes one beat per item: action_i
//   picks the direction (0: julian_day_i to date, 1: day/month/year to JD).
//   Output channel (out_valid_o / out_ready_i) returns exactly one beat per
//   item, in order. Fields of the unused direction read zero; range_error_o
//   flags a JD outside 2299161..5373484 or a year outside 1582..9999, and
//   then every result field reads zero. Day of month is not checked.
// Timing
//   Thirteen register stages, passed in order. One beat enters per cycle
//   while the output is not stalled; each constant division takes a
//   reciprocal multiply, a back multiply and a compare-correct step in
//   stages of their own.
// Reset and stall
//   Reset empties every stage. When the receiver stalls, the last stage holds
//   its beat and upstream stages keep advancing into empty slots, so input
//   stays ready until all 13 stages hold a beat.
`include "julian_day_gregorian_convert_macros.svh"

module julian_day_gregorian_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [22:0] julian_day_i,
  input  logic [4:0]  day_i,
  input  logic [3:0]  month_i,
  input  logic [13:0] year_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [22:0] out_julian_day_o,
  output logic [4:0]  out_day_o,
  output logic [3:0]  out_month_o,
  output logic [13:0] out_year_o,
  output logic        range_error_o
);
  import jdgc_pkg::*;

  item_t           stg_q [NSTG];
  item_t           stg_d [NSTG];
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  logic [24:0] diff1;
  logic [14:0] diffa;
  logic [27:0] diff3;
  logic [25:0] dprod;
  logic [4:0]  e_cnt;
  logic [8:0]  dy9;
  logic [4:0]  mo5;
  logic [14:0] yr15;
  logic        early;

  // Advance a stage when it is empty or its successor advances.
  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_comb begin
    for (int k = 1; k < NSTG; k++) begin
      stg_d[k] = stg_q[k-1];
    end

    // Stage 0: capture, range check, fold January, February (and month zero)
    // into the previous year
    early          = (month_i < 4'd3);
    stg_d[0]       = '0;
    stg_d[0].action = action_i;
    stg_d[0].err   = action_i ? ((year_i < YEAR_MIN) || (year_i > YEAR_MAX))
                              : ((julian_day_i < JD_MIN) || (julian_day_i > JD_MAX));
    stg_d[0].z     = julian_day_i;
    stg_d[0].n1    = 24'({julian_day_i, 2'b00} - N1_BIAS);
    stg_d[0].day   = day_i;
    stg_d[0].yr_p  = year_i - 14'(early);
    stg_d[0].mo_p  = early ? month_i + 4'd12 : month_i;

    // Stage 1: reciprocal products and 1461 * year for the JD sum
    stg_d[1].p1 = 31'(stg_q[0].n1) * 31'(K1);
    stg_d[1].pa = 22'(stg_q[0].yr_p) * 22'(KA);
    stg_d[1].dd = 25'(stg_q[0].yr_p) * 25'(C1461);

    // Stage 2: estimated quotients and back products
    stg_d[2].q1e   = stg_q[1].p1[30:24];
    stg_d[2].back1 = 25'(stg_q[1].p1[30:24]) * 25'(D1);
    stg_d[2].qa    = stg_q[1].pa[21:14];
    stg_d[2].backa = 15'(stg_q[1].pa[21:14]) * 15'(DA);

    // Stage 3: correct the estimates by one where the remainder overflows, add dd bias
    diff1        = 25'(stg_q[2].n1) - stg_q[2].back1;
    diffa        = 15'(stg_q[2].yr_p) - stg_q[2].backa;
    stg_d[3].w   = stg_q[2].q1e + 7'(diff1 >= 25'(D1));
    stg_d[3].a   = stg_q[2].qa + 8'(diffa >= 15'(DA));
    stg_d[3].dd  = stg_q[2].dd + 25'(DD_BIAS);

    // Stage 4: b = z + 1 + w - w/4 + 1524; date to JD sum completes here
    stg_d[4].b  = stg_q[3].z + 23'(stg_q[3].w) - 23'(stg_q[3].w >> 2) + 23'(B_BIAS);
    stg_d[4].jd = 23'(stg_q[3].dd[24:2])
                + 23'(month_days(5'(stg_q[3].mo_p) + 5'd1))
                + 23'(stg_q[3].day)
                + 23'(stg_q[3].a >> 2)
                - 23'(stg_q[3].a)
                - 23'(JD_BIAS);

    // Stage 5: 20b - 2442
    stg_d[5].n3 = 27'({stg_q[4].b, 4'b0000}) + 27'({stg_q[4].b, 2'b00}) - 27'(N3_BIAS);

    // Stage 6: reciprocal product for /7305
    stg_d[6].p3 = 42'(stg_q[5].n3) * 42'(K3);

    // Stage 7: estimate and back product
    stg_d[7].q3e   = stg_q[6].p3[41:27];
    stg_d[7].back3 = 28'(stg_q[6].p3[41:27]) * 28'(D3);

    // Stage 8: correct to c
    diff3      = 28'(stg_q[7].n3) - stg_q[7].back3;
    stg_d[8].c = stg_q[7].q3e + 15'(diff3 >= 28'(D3));

    // Stage 9: d = floor(1461c / 4)
    dprod      = 26'(stg_q[8].c) * 26'(C1461);
    stg_d[9].d = dprod[25:2];

    // Stage 10: days past the March-based year start
    stg_d[10].g = 9'(stg_q[9].b - 23'(stg_q[9].d));

    // Stage 11: e = floor(g / 30.6001) as a count of passed month starts
    e_cnt = '0;
    for (int k = 1; k <= 16; k++) begin
      e_cnt = e_cnt + 5'(stg_q[10].g > month_days(5'(k)));
    end
    stg_d[11].e = e_cnt;

    // Stage 12: day, month, year and result masking
    dy9  = stg_q[11].g - month_days(stg_q[11].e);
    mo5  = (stg_q[11].e < 5'd14) ? stg_q[11].e - 5'd1 : stg_q[11].e - 5'd13;
    yr15 = (mo5 < 5'd3) ? stg_q[11].c - 15'(YR_OFS0) : stg_q[11].c - 15'(YR_OFS1);
    stg_d[12].res_jd = (stg_q[11].action && !stg_q[11].err) ? stg_q[11].jd : '0;
    stg_d[12].res_d  = (!stg_q[11].action && !stg_q[11].err) ? dy9[4:0] : '0;
    stg_d[12].res_m  = (!stg_q[11].action && !stg_q[11].err) ? mo5[3:0] : '0;
    stg_d[12].res_y  = (!stg_q[11].action && !stg_q[11].err) ? yr15[13:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSTG; k++) begin
      if (en[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign out_valid_o      = v_q[NSTG-1];
  assign out_julian_day_o = stg_q[NSTG-1].res_jd;
  assign out_day_o        = stg_q[NSTG-1].res_d;
  assign out_month_o      = stg_q[NSTG-1].res_m;
  assign out_year_o       = stg_q[NSTG-1].res_y;
  assign range_error_o    = stg_q[NSTG-1].err;

  `JDG_ASSERT_IMPL(a_full_when_blocked, clk_i, rst_ni, !in_ready_o, (&v_q) && !out_ready_i)
  `JDG_ASSERT_NEXT(a_accept_lands, clk_i, rst_ni, in_valid_i && in_ready_o, v_q[0])
  `JDG_ASSERT_IMPL(a_error_zeroes, clk_i, rst_ni, out_valid_o && range_error_o,
                   (out_julian_day_o == 23'd0) && (out_day_o == 5'd0)
                   && (out_month_o == 4'd0) && (out_year_o == 14'd0))
  `JDG_ASSERT_IMPL(a_date_month_ok, clk_i, rst_ni, out_valid_o && (out_day_o != 5'd0),
                   (out_month_o >= 4'd1) && (out_month_o <= 4'd12)
                   && (out_julian_day_o == 23'd0))

endmodule

/* sim/testbench.sv */
// Testbench for the Julian day number <-> Gregorian date converter.
module testbench;

  // Supported input ranges of the conversion
  localparam int unsigned JD_LOW    = 2299161;
  localparam int unsigned JD_HIGH   = 5373484;
  localparam int unsigned YEAR_LOW  = 1582;
  localparam int unsigned YEAR_HIGH = 9999;

  // Direction codes carried on action_i
  typedef enum logic {
    ACT_JD_TO_DATE = 1'b0,
    ACT_DATE_TO_JD = 1'b1
  } action_e;

  typedef struct {
    logic [22:0] jd;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        err;
  } conversion_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic        action_i     = ACT_JD_TO_DATE;
  logic [22:0] julian_day_i = '0;
  logic [4:0]  day_i        = '0;
  logic [3:0]  month_i      = '0;
  logic [13:0] year_i       = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [22:0] out_julian_day_o;
  logic [4:0]  out_day_o;
  logic [3:0]  out_month_o;
  logic [13:0] out_year_o;
  logic        range_error_o;

  conversion_t pending_conversions[$];
  int          mismatch_count = 0;
  bit          idle_on = 1'b1;
  int          stall_left = 0;

  julian_day_gregorian_convert dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Generous cap: every beat waiting out the longest gap and stall is far below it.
  initial begin
    #2000000;
    $display("julian_day_gregorian_convert verification failed");
    $finish;
  end

  // Meeus conversion with exact integer ratios in place of the float constants.
  function automatic conversion_t predict_conversion(logic act, logic [22:0] jd,
                                                     logic [4:0] dy, logic [3:0] mo,
                                                     logic [13:0] yr);
    conversion_t r;
    longint z, w, x, a, b, c, d, e, f, m, y, mon;
    r = '{jd: '0, day: '0, month: '0, year: '0, err: 1'b0};
    if (act == ACT_JD_TO_DATE) begin
      z = jd;
      if (z < JD_LOW || z > JD_HIGH) begin
        r.err = 1'b1;
      end else begin
        w = (4 * z - 7468865) / 146097;
        x = w / 4;
        a = z + 1 + w - x;
        b = a + 1524;
        c = (20 * b - 2442) / 7305;
        d = (1461 * c) / 4;
        e = (10000 * (b - d)) / 306001;
        f = (306001 * e) / 10000;
        mon = (e < 14) ? e - 1 : e - 13;
        r.day   = 5'(b - d - f);
        r.month = 4'(mon);
        r.year  = 14'((mon < 3) ? c - 4715 : c - 4716);
      end
    end else begin
      y = yr;
      m = mo;
      if (y < YEAR_LOW || y > YEAR_HIGH) begin
        r.err = 1'b1;
      end else begin
        // January and February (and month zero) count in the previous year
        if (m < 3) begin
          y = y - 1;
          m = m + 12;
        end
        a = y / 100;
        b = a / 4;
        c = 2 - a + b;
        d = (1461 * (y + 4716)) / 4;
        e = (306001 * (m + 1)) / 10000;
        r.jd = 23'(d + e + longint'(dy) + c - 1524);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("%0t: %s", $time, msg);
  endtask

  // Drive one beat; enter and leave at a falling edge with valid still high.
  task automatic send_beat(logic act, logic [22:0] jd, logic [4:0] dy, logic [3:0] mo,
                           logic [13:0] yr);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i = 1'b0;
      repeat (gap) begin
        // scramble the idle payload; the block must ignore it
        action_i     = 1'($urandom);
        julian_day_i = 23'($urandom);
        day_i        = 5'($urandom);
        month_i      = 4'($urandom);
        year_i       = 14'($urandom);
        @(negedge clk_i);
      end
    end
    in_valid_i   = 1'b1;
    action_i     = act;
    julian_day_i = jd;
    day_i        = dy;
    month_i      = mo;
    year_i       = yr;
    do @(posedge clk_i); while (!in_ready_o);
    pending_conversions.push_back(predict_conversion(act, jd, dy, mo, yr));
    @(negedge clk_i);
  endtask

  function automatic logic [22:0] pick_jd();
    case ($urandom_range(0, 19))
      0, 1:    return 23'($urandom);
      2:       return 23'(JD_LOW - 200 + $urandom_range(0, 400));
      3:       return 23'(JD_HIGH - 200 + $urandom_range(0, 400));
      default: return 23'($urandom_range(JD_LOW, JD_HIGH));
    endcase
  endfunction

  task automatic pick_date(output logic [4:0] dy, output logic [3:0] mo,
                           output logic [13:0] yr);
    case ($urandom_range(0, 19))
      0, 1:    yr = 14'($urandom);
      2:       yr = 14'(YEAR_LOW - 3 + $urandom_range(0, 6));
      3:       yr = 14'(YEAR_HIGH - 3 + $urandom_range(0, 6));
      4:       yr = 14'(100 * $urandom_range(16, 99));  // century years
      default: yr = 14'($urandom_range(YEAR_LOW, YEAR_HIGH));
    endcase
    mo = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
    case ($urandom_range(0, 9))
      0:       dy = 5'($urandom);
      1, 2:    dy = 5'($urandom_range(28, 31));
      default: dy = 5'($urandom_range(1, 31));
    endcase
  endtask

  task automatic send_jd(logic [22:0] jd);
    send_beat(ACT_JD_TO_DATE, jd, 5'($urandom), 4'($urandom), 14'($urandom));
  endtask

  task automatic send_date(logic [4:0] dy, logic [3:0] mo, logic [13:0] yr);
    send_beat(ACT_DATE_TO_JD, 23'($urandom), dy, mo, yr);
  endtask

  task automatic send_random_item(logic act);
    logic [4:0]  dy;
    logic [3:0]  mo;
    logic [13:0] yr;
    pick_date(dy, mo, yr);
    send_beat(act, pick_jd(), dy, mo, yr);
  endtask

  // Range edges, field extremes and a few well-known dates, JD side.
  task automatic test_jd_edges();
    send_jd(23'd0);
    send_jd(23'(JD_LOW - 1));
    send_jd(23'(JD_LOW));
    send_jd(23'd2451545);
    send_jd(23'd2451604);
    send_jd(23'(JD_HIGH));
    send_jd(23'(JD_HIGH + 1));
    send_jd(23'h7FFFFF);
  endtask

  // Year edges, leap days, unchecked day values and months outside 1..12.
  task automatic test_date_edges();
    send_date(5'd15, 4'd10, 14'(YEAR_LOW));
    send_date(5'd1, 4'd1, 14'(YEAR_LOW - 1));
    send_date(5'd31, 4'd12, 14'(YEAR_HIGH));
    send_date(5'd1, 4'd1, 14'(YEAR_HIGH + 1));
    send_date(5'd0, 4'd1, 14'h3FFF);
    send_date(5'd29, 4'd2, 14'd2000);
    send_date(5'd0, 4'd0, 14'd2000);
    send_date(5'd31, 4'd15, 14'(YEAR_HIGH));
    send_date(5'd1, 4'd13, 14'd1600);
    send_date(5'd1, 4'd3, 14'd1900);
    send_date(5'd31, 4'd14, 14'd2024);
  endtask

  task automatic test_jd_to_date_random(int count);
    repeat (count) send_random_item(ACT_JD_TO_DATE);
  endtask

  task automatic test_date_to_jd_random(int count);
    repeat (count) send_random_item(ACT_DATE_TO_JD);
  endtask

  task automatic test_mixed_random(int count);
    repeat (count) send_random_item(logic'($urandom_range(0, 1)));
  endtask

  // Full rate: no gaps from the sender, and the receiver starts no new stalls.
  task automatic test_back_to_back(int count);
    idle_on = 1'b0;
    repeat (count) send_random_item(logic'($urandom_range(0, 1)));
  endtask

  // Receiver: stall in random bursts while idling is on.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left  = $urandom_range(1, 11) - 1;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk_i) begin
    conversion_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_conversions.size() == 0) begin
        report_mismatch("result beat with no item outstanding");
      end else begin
        want = pending_conversions.pop_front();
        if (out_julian_day_o !== want.jd)
          report_mismatch($sformatf("out_julian_day got %0d expected %0d",
                                    out_julian_day_o, want.jd));
        if (out_day_o !== want.day)
          report_mismatch($sformatf("out_day got %0d expected %0d", out_day_o, want.day));
        if (out_month_o !== want.month)
          report_mismatch($sformatf("out_month got %0d expected %0d",
                                    out_month_o, want.month));
        if (out_year_o !== want.year)
          report_mismatch($sformatf("out_year got %0d expected %0d", out_year_o, want.year));
        if (range_error_o !== want.err)
          report_mismatch($sformatf("range_error got %0b expected %0b",
                                    range_error_o, want.err));
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_jd_edges();
    test_date_edges();
    test_jd_to_date_random(450);
    test_date_to_jd_random(450);
    test_mixed_random(550);
    test_back_to_back(480);

    // Drain: drop valid, wait for every prediction, then let the pipe settle.
    in_valid_i = 1'b0;
    while (pending_conversions.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("julian_day_gregorian_convert verification clean");
    end else begin
      $display("julian_day_gregorian_convert verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/jdgc_pkg.sv
sv/julian_day_gregorian_convert.sv
sim/testbench.sv
